[src/tlos_pkg.sv]
// Package for the terrain line-of-sight block: grid geometry, payload types,
// controller state type and the command/status structs. No dependencies.
package tlos_pkg;

    localparam int GRID_ROWS  = 128;
    localparam int GRID_COLS  = 128;
    localparam int ELEV_BITS  = 24;
    localparam int ROW_BITS   = $clog2(GRID_ROWS);
    localparam int COL_BITS   = $clog2(GRID_COLS);
    localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
    localparam int CELLS      = GRID_ROWS * GRID_COLS;
    localparam int STEP_BITS  = 8;
    localparam int D2_BITS    = 2 * STEP_BITS;
    localparam int EYE_BITS   = ELEV_BITS + 2;
    localparam int RISE_BITS  = EYE_BITS + 1;
    localparam int ACC_BITS   = RISE_BITS + STEP_BITS + 5;
    localparam int PROD_BITS  = ELEV_BITS + STEP_BITS + 1;
    localparam int Q_BITS     = STEP_BITS + 2;

    localparam logic [1:0] CFG_MAX_DIST  = 2'd0;
    localparam logic [1:0] CFG_VIEW_HGT  = 2'd1;
    localparam logic [1:0] CFG_TGT_HGT   = 2'd2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic        func;
        logic [23:0] cell_elevation;
        logic [6:0]  cell_row;
        logic [6:0]  cell_col;
        logic [6:0]  view_row;
        logic [6:0]  view_col;
        logic [23:0] view_ground;
    } t_in;

    typedef struct packed {
        logic       visible;
        logic [6:0] target_row;
        logic [6:0] target_col;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_TOP,
        ST_SETUP,
        ST_WALK,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic capture;
        logic write;
        logic sqrt_step;
        logic setup;
    } t_cmd;

    typedef struct packed {
        logic sqrt_last;
        logic far;
        logic zero;
        logic walk_fail;
        logic walk_done;
    } t_sts;

endpackage

[src/tlos_dp.sv]
// Datapath: elevation store, bit-serial square root, sample walk pipeline.
// Depends on tlos_pkg.
module tlos_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tlos_pkg::t_in          i_in,
    input  tlos_pkg::t_cmd         i_cmd,
    input  logic [7:0]             i_max_dist,
    input  logic [15:0]            i_view_hgt,
    input  logic [15:0]            i_tgt_hgt,
    output tlos_pkg::t_sts         o_sts,
    output logic [6:0]             o_trow,
    output logic [6:0]             o_tcol
);
    import tlos_pkg::*;

    logic [ELEV_BITS-1:0] r_mem [CELLS];
    logic [ELEV_BITS-1:0] r_rdata;
    logic [ADDR_BITS-1:0] rd_addr;

    logic [ROW_BITS-1:0]  r_trow, r_vrow;
    logic [COL_BITS-1:0]  r_tcol, r_vcol;
    logic [23:0]          r_ground;
    logic signed [Q_BITS-1:0] r_dr, r_dc;
    logic [D2_BITS-1:0]   r_d2;
    logic [STEP_BITS-1:0] r_root;
    logic [2:0]           r_bit;

    logic signed [EYE_BITS-1:0]  eye;
    logic signed [RISE_BITS-1:0] r_rise;
    logic signed [ACC_BITS-1:0]  r_acc;

    logic                 r_issue;
    logic [STEP_BITS-1:0] r_p;
    logic signed [Q_BITS-1:0] r_qr, r_qc, r_remr, r_remc;
    logic signed [Q_BITS-1:0] n_qr, n_qc, n_remr, n_remc;
    logic signed [ACC_BITS-1:0] n_acc;

    logic                 r_s1_v, r_s1_last, r_s2_v, r_s2_last;
    logic signed [ACC_BITS-1:0]  r_s1_acc, r_s2_acc;
    logic signed [PROD_BITS-1:0] r_prod;
    logic                 fail;

    logic signed [Q_BITS-1:0] dr_in, dc_in;
    logic [STEP_BITS-1:0] trial;
    logic [D2_BITS-1:0]   trial_sq;
    logic signed [Q_BITS-1:0] step_s;
    logic [ROW_BITS:0]    walk_row;
    logic [COL_BITS:0]    walk_col;

    assign dr_in = $signed({3'b000, i_in.cell_row}) - $signed({3'b000, i_in.view_row});
    assign dc_in = $signed({3'b000, i_in.cell_col}) - $signed({3'b000, i_in.view_col});
    assign step_s = $signed({2'b00, r_root});

    assign eye = EYE_BITS'($signed(r_ground)) + $signed({10'd0, i_view_hgt});

    // one square-root bit per cycle
    assign trial    = r_root | STEP_BITS'(1 << r_bit);
    assign trial_sq = trial * trial;

    // next sample: floor(p*d/steps) kept as quotient and remainder (|d| <= steps)
    function automatic logic signed [2*Q_BITS-1:0] adv(
        input logic signed [Q_BITS-1:0] q, input logic signed [Q_BITS-1:0] rem,
        input logic signed [Q_BITS-1:0] d, input logic signed [Q_BITS-1:0] s);
        logic signed [Q_BITS-1:0] t;
        logic signed [Q_BITS-1:0] qq;
        t  = rem + d;
        qq = q;
        if (t >= s) begin
            t  = t - s;
            qq = q + Q_BITS'(1);
        end else if (t < 0) begin
            t  = t + s;
            qq = q - Q_BITS'(1);
        end
        return {qq, t};
    endfunction

    always_comb begin
        {n_qr, n_remr} = adv(r_qr, r_remr, r_dr, step_s);
        {n_qc, n_remc} = adv(r_qc, r_remc, r_dc, step_s);
        n_acc    = r_acc + ACC_BITS'(r_rise);
        walk_row = (ROW_BITS+1)'($signed({3'b000, r_vrow}) + n_qr);
        walk_col = (COL_BITS+1)'($signed({3'b000, r_vcol}) + n_qc);
        if (r_issue)
            rd_addr = {walk_row[ROW_BITS-1:0], walk_col[COL_BITS-1:0]};
        else
            rd_addr = {r_trow, r_tcol};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write)
            r_mem[{i_in.cell_row, i_in.cell_col}] <= i_in.cell_elevation;
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_trow   <= i_in.cell_row;
            r_tcol   <= i_in.cell_col;
            r_vrow   <= i_in.view_row;
            r_vcol   <= i_in.view_col;
            r_ground <= i_in.view_ground;
            r_dr     <= dr_in;
            r_dc     <= dc_in;
            r_d2     <= D2_BITS'(dr_in * dr_in) + D2_BITS'(dc_in * dc_in);
            r_root   <= '0;
            r_bit    <= 3'd7;
        end else if (i_cmd.sqrt_step) begin
            if (trial_sq <= r_d2)
                r_root <= trial;
            r_bit <= r_bit - 3'd1;
        end
        if (i_cmd.setup) begin
            r_rise <= RISE_BITS'($signed(r_rdata)) + $signed({11'd0, i_tgt_hgt})
                      - RISE_BITS'(eye);
            r_acc  <= ACC_BITS'(eye * $signed({1'b0, r_root}));
            r_p    <= STEP_BITS'(1);
            r_qr   <= '0;
            r_qc   <= '0;
            r_remr <= '0;
            r_remc <= '0;
        end else if (r_issue) begin
            r_p    <= r_p + STEP_BITS'(1);
            r_qr   <= n_qr;
            r_qc   <= n_qc;
            r_remr <= n_remr;
            r_remc <= n_remc;
            r_acc  <= n_acc;
        end
        r_s1_acc  <= n_acc;
        r_s1_last <= (r_p == r_root);
        r_prod    <= $signed(r_rdata) * $signed({1'b0, r_root});
        r_s2_acc  <= r_s1_acc;
        r_s2_last <= r_s1_last;
    end

    assign fail = r_s2_v && (ACC_BITS'(r_prod) > r_s2_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || fail || (r_s2_v && r_s2_last)) begin
            r_issue <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
        end else begin
            if (i_cmd.setup)
                r_issue <= 1'b1;
            else if (r_issue && r_p == r_root)
                r_issue <= 1'b0;
            r_s1_v <= r_issue;
            r_s2_v <= r_s1_v;
        end
    end

    assign o_sts.sqrt_last = (r_bit == 3'd0);
    assign o_sts.far       = (r_root > i_max_dist);
    assign o_sts.zero      = (r_root == '0);
    assign o_sts.walk_fail = fail;
    assign o_sts.walk_done = r_s2_v && r_s2_last && !fail;
    assign o_trow = r_trow;
    assign o_tcol = r_tcol;

endmodule

[src/tlos_ctrl.sv]
// Controller state machine for the line-of-sight block.
// Depends on tlos_pkg.
module tlos_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_func,
    input  logic            i_out_free,
    input  tlos_pkg::t_sts  i_sts,
    output logic            o_in_stall,
    output tlos_pkg::t_cmd  o_cmd,
    output logic            o_res_load,
    output logic            o_res_vis
);
    import tlos_pkg::*;

    t_state r_state, n_state;
    logic   r_vis, n_vis;
    logic   acc;

    assign acc = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_vis   = r_vis;
        unique case (r_state)
            ST_IDLE:  if (acc && i_func == FUNC_QUERY) n_state = ST_SQRT;
            ST_SQRT:  if (i_sts.sqrt_last) n_state = ST_TOP;
            ST_TOP: begin
                if (i_sts.far) begin
                    n_vis = 1'b0;
                    n_state = ST_FIN;
                end else if (i_sts.zero) begin
                    n_vis = 1'b1;
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: n_state = ST_WALK;
            ST_WALK: begin
                if (i_sts.walk_fail) begin
                    n_vis = 1'b0;
                    n_state = ST_FIN;
                end else if (i_sts.walk_done) begin
                    n_vis = 1'b1;
                    n_state = ST_FIN;
                end
            end
            ST_FIN:   if (i_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_res_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.capture = acc && i_func == FUNC_QUERY;
                o_cmd.write   = acc && i_func == FUNC_LOAD;
            end
            ST_SQRT:  o_cmd.sqrt_step = 1'b1;
            ST_SETUP: o_cmd.setup = 1'b1;
            ST_FIN:   o_res_load = i_out_free;
            default: ;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_res_vis  = r_vis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_vis <= n_vis;
    end

endmodule

[src/terrain_line_of_sight_viewshed.sv]
// Top level of the terrain line-of-sight block: config registers, result register,
// controller and datapath. Depends on tlos_pkg, tlos_ctrl, tlos_dp.
//
//  channel | signals                               | direction
//  in      | i_in_valid, o_in_stall, i_in (t_in)   | item in
//  out     | o_out_valid, i_out_stall, o_out       | result out
//  cfg     | i_cfg_valid, o_cfg_ready, index, data | register write
//
// A load writes the store and gives no result. A query is taken, then runs the
// bit-serial square root, reads the target and sets up, walks the samples through
// the store read port, checks the samples and posts the result, keeping the input
// stalled until it is posted; a far or zero-distance query skips the walk.
// Reset (synchronous, active low) restores the config and control registers; the store is not cleared.
// A finished result waits in the output register while the next item is taken.
module terrain_line_of_sight_viewshed (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  tlos_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output tlos_pkg::t_out  o_out,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data
);
    import tlos_pkg::*;

    logic [7:0]  r_max_dist;
    logic [15:0] r_view_hgt, r_tgt_hgt;
    t_cmd        cmd;
    t_sts        sts;
    logic        out_free, res_load, res_vis;
    logic [6:0]  trow, tcol;

    assign o_cfg_ready = 1'b1;
    // output slot free when empty or being drained this cycle
    assign out_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= 8'd255;
            r_view_hgt <= '0;
            r_tgt_hgt  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_DIST: r_max_dist <= i_cfg_data[7:0];
                CFG_VIEW_HGT: r_view_hgt <= i_cfg_data;
                CFG_TGT_HGT:  r_tgt_hgt  <= i_cfg_data;
                default: ;  // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (res_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
        if (res_load)
            o_out <= '{visible: res_vis, target_row: trow, target_col: tcol};
    end

    tlos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in.func),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .o_res_load (res_load),
        .o_res_vis  (res_vis)
    );

    tlos_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .i_max_dist (r_max_dist),
        .i_view_hgt (r_view_hgt),
        .i_tgt_hgt  (r_tgt_hgt),
        .o_sts      (sts),
        .o_trow     (trow),
        .o_tcol     (tcol)
    );

endmodule

[src/tlos_checker.sv]
// Port-level checks for the line-of-sight block, bound to the top level.
// Depends on tlos_pkg.
module tlos_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           o_in_stall,
    input  tlos_pkg::t_in  i_in,
    input  logic           o_out_valid,
    input  logic           i_out_stall,
    input  tlos_pkg::t_out o_out,
    input  logic           o_cfg_ready
);
    import tlos_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge i_clk) o_cfg_ready)
        else $error("config port not ready");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.func == FUNC_QUERY |=> o_in_stall)
        else $error("query did not occupy the block");

    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.func == FUNC_LOAD |=> !o_in_stall)
        else $error("load stalled the input");

endmodule

bind terrain_line_of_sight_viewshed tlos_checker u_tlos_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out),
    .o_cfg_ready (o_cfg_ready)
);
